### sv/iwt_pkg.sv
// Package for the identifier word tokeniser: item kind codes, the emission
// state type and the character class functions. No dependencies.
package iwt_pkg;

  // Kind of an input transaction.
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_EOF  = 1'b1;

  // Emission sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } iwt_state_e;

  function automatic logic is_alpha(input logic [7:0] b);
    is_alpha = ((b >= 8'd65) && (b <= 8'd90)) || ((b >= 8'd97) && (b <= 8'd122));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= 8'd48) && (b <= 8'd57);
  endfunction

endpackage

### sv/identifier_word_tokenizer_top.sv
// Top level of the identifier word tokeniser: splits a byte stream into words.
// Depends on iwt_pkg and on the generic RAM iwt_ram.
//
//   Channel  | Direction | Handshake               | Payload
//   ---------+-----------+-------------------------+----------------------------
//   input    | in        | in_valid_i / in_stall_o | kind_i, data_byte_i
//   output   | out       | out_valid_o/ out_stall_i| word_char_o, word_last_o
//
// A byte transaction that emits no word is taken while the sequencer is idle,
// and the next may follow straight away. A transaction that sends out a word
// holds the input stalled while each character passes a RAM read state and
// a load state that moves the read data into the output register, set by
// the single read port of the word buffer and the one-deep output register.
// A stall on the output side simply extends the load state of that character.
// Reset clears the length counter, the sequencer and the output valid flag;
// the word buffer needs no clearing because only characters written for the
// current word are ever read back.
module identifier_word_tokenizer_top import iwt_pkg::*; #(
  parameter int WORD_MAX = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] word_char_o,
  output logic       word_last_o
);

  localparam int AW = $clog2(WORD_MAX);
  localparam int LW = $clog2(WORD_MAX + 1);
  localparam logic [LW-1:0] LenMax = LW'(WORD_MAX);
  localparam logic [LW-1:0] LenOne = LW'(1);

  iwt_state_e state_q, state_d;

  // Length of the word being collected; it saturates at WORD_MAX once the
  // word has been emitted early or was too long.
  logic [LW-1:0] len_q, len_d;
  // Number of characters of the word being emitted and the read index.
  logic [LW-1:0] emit_len_q, emit_len_d;
  logic [AW-1:0] idx_q, idx_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic       out_last_q, out_last_d;

  logic          in_accept;
  logic          alpha, alnum, word_end;
  logic          emit_start;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_re;
  logic [7:0]    ram_rdata;
  logic          out_free;
  logic          load_out;
  logic          idx_last;

  assign alpha     = is_alpha(data_byte_i);
  assign alnum     = alpha || is_digit(data_byte_i);
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign idx_last  = (LW'(idx_q) == (emit_len_q - LenOne));

  // A word is closed by end of file or by any byte that is not a letter or
  // digit while a word is open.
  assign word_end = (kind_i == KIND_EOF) || ((len_q != '0) && !alnum);

  // Per-transaction update of the length counter and the buffer write.
  always_comb begin
    len_d      = len_q;
    emit_len_d = emit_len_q;
    emit_start = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    if (in_accept) begin
      if (word_end) begin
        // Only words of two or more characters not yet emitted go out.
        if ((len_q > LenOne) && (len_q < LenMax)) begin
          emit_start = 1'b1;
          emit_len_d = len_q;
        end
        len_d = '0;
      end else if (len_q == '0) begin
        if (alpha) begin
          ram_we = 1'b1;
          len_d  = LenOne;
        end
      end else if (len_q < LenMax) begin
        ram_we    = 1'b1;
        ram_waddr = len_q[AW-1:0];
        // On the last storable character the word goes out truncated; the
        // character just written is not part of it.
        if ((len_q + LenOne) == LenMax) begin
          emit_start = 1'b1;
          emit_len_d = len_q;
        end
        len_d = len_q + LenOne;
      end
    end
  end

  // Next state of the emission sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (emit_start) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          state_d = idx_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = 1'b1;
    ram_re     = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_LOAD: begin
        load_out = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Read index and output register.
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (emit_start) begin
      idx_d = '0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
      out_char_d  = ram_rdata;
      out_last_d  = idx_last;
      if (!idx_last) begin
        idx_d = idx_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    emit_len_q <= emit_len_d;
    idx_q      <= idx_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  iwt_ram #(
    .WIDTH(8),
    .DEPTH(WORD_MAX)
  ) u_word_buffer (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(data_byte_i),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign word_char_o = out_char_q;
  assign word_last_o = out_last_q;

endmodule

### sv/iwt_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; no package needed.
module iwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### dv/tokenizer_checker.sv
// Checker for the identifier word tokeniser: watches both channels, predicts
// the emitted word characters and compares them. Depends on iwt_pkg.
module tokenizer_checker import iwt_pkg::*; #(
  parameter int WORD_MAX = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       kind_i,
  input  logic [7:0] data_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] word_char_i,
  input  logic       word_last_i,
  output int         mismatches_o,
  output int         chars_pending_o,
  output int         bytes_taken_o,
  output int         words_checked_o,
  output int         chars_checked_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } word_char_t;

  word_char_t  expected_chars[$];
  logic [7:0]  word_buf [WORD_MAX];
  int unsigned word_len;

  task automatic report_mismatch(input string what);
    mismatches_o++;
    if (mismatches_o <= 100) begin
      $display("[%0t] tokeniser mismatch: %s", $time, what);
    end
  endtask

  // Queue the first n buffered characters as one word; shorter words vanish.
  function automatic void queue_word(input int unsigned n);
    if (n < 2) begin
      return;
    end
    for (int unsigned i = 0; i < n; i++) begin
      expected_chars.push_back('{ch: word_buf[i], last: (i + 1 == n)});
    end
  endfunction

  task automatic take_byte(input logic kind, input logic [7:0] b);
    logic letter;
    logic alnum;
    letter = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    alnum  = letter || ((b >= 8'h30) && (b <= 8'h39));
    if (kind == KIND_EOF) begin
      if (word_len > 0 && word_len < WORD_MAX) begin
        queue_word(word_len);
      end
      word_len = 0;
    end else if (word_len == 0) begin
      if (letter) begin
        word_buf[0] = b;
        word_len    = 1;
      end
    end else if (!alnum) begin
      if (word_len < WORD_MAX) begin
        queue_word(word_len);
      end
      word_len = 0;
    end else if (word_len < WORD_MAX) begin
      // The character that fills the buffer is stored but not emitted.
      word_buf[word_len] = b;
      if (word_len + 1 == WORD_MAX) begin
        queue_word(word_len);
      end
      word_len++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    word_char_t head;
    if (!rst_ni) begin
      expected_chars.delete();
      word_len        = 0;
      chars_pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%02h (last %0b)",
                                    word_char_i, word_last_i));
        end else begin
          head = expected_chars.pop_front();
          if (word_char_i !== head.ch) begin
            report_mismatch($sformatf("word_char 0x%02h, expected 0x%02h",
                                      word_char_i, head.ch));
          end
          if (word_last_i !== head.last) begin
            report_mismatch($sformatf("word_last %0b, expected %0b on char 0x%02h",
                                      word_last_i, head.last, head.ch));
          end
          chars_checked_o++;
          if (head.last) begin
            words_checked_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        bytes_taken_o++;
        take_byte(kind_i, data_byte_i);
      end
      chars_pending_o = expected_chars.size();
    end
  end

endmodule

### dv/testbench.sv
// Top of the identifier word tokeniser testbench: clock, reset, stimulus,
// output back-pressure, watchdog and verdict. Depends on iwt_pkg, the block
// and tokenizer_checker.
module testbench import iwt_pkg::*;;

  localparam int WORD_MAX       = 32;
  // Cycles without any transaction on either channel before the run is abandoned.
  localparam int STUCK_LIMIT    = 3000;
  localparam int HOLDOFF_CYCLES = 200;
  localparam int RANDOM_ITEMS   = 260;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       kind_i;
  logic [7:0] data_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] word_char_o;
  logic       word_last_o;

  int mismatches;
  int chars_pending;
  int bytes_taken;
  int words_checked;
  int chars_checked;

  // Shared between the stimulus and the back-pressure process.
  bit noise_on     = 1'b1;
  bit holdoff_go   = 1'b0;
  bit holdoff_done = 1'b0;

  int long_words;
  int stuck_cycles;

  identifier_word_tokenizer_top #(
    .WORD_MAX(WORD_MAX)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .data_byte_i(data_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .word_char_o(word_char_o),
    .word_last_o(word_last_o)
  );

  tokenizer_checker #(
    .WORD_MAX(WORD_MAX)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .kind_i         (kind_i),
    .data_byte_i    (data_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .word_char_i    (word_char_o),
    .word_last_i    (word_last_o),
    .mismatches_o   (mismatches),
    .chars_pending_o(chars_pending),
    .bytes_taken_o  (bytes_taken),
    .words_checked_o(words_checked),
    .chars_checked_o(chars_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: any transaction on either channel restarts the count. The long
  // receiver hold-off and the drain at the end both stay well inside it.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Watchdog expired with %0d characters still expected", chars_pending);
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver back-pressure. All changes happen at the falling edge, and the
  // signal gets at most one assignment per falling edge. When the stimulus
  // asks for it, the stall is held high for a long stretch, counted here, so
  // that the block fills up and in turn stalls its input.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holdoff_go && !holdoff_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLDOFF_CYCLES - 1) @(negedge clk_i);
        holdoff_done = 1'b1;
      end else begin
        out_stall_i <= noise_on && ($urandom_range(99) < 34);
      end
    end
  end

  // Offer one transaction, starting at a falling edge, with random idle
  // cycles in front of it. Returns at the falling edge after acceptance, so
  // valid is never dropped and raised within the same time step.
  task automatic drive_item(input logic kind, input logic [7:0] b);
    while (noise_on && ($urandom_range(99) < 34)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      drive_item(KIND_DATA, s[i]);
    end
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1) == 0) begin
      return 8'h41 + 8'($urandom_range(25));
    end
    return 8'h61 + 8'($urandom_range(25));
  endfunction

  // Any byte that is neither letter nor digit; the ranges hug the borders of
  // the letter and digit classes and half the picks lie above 127.
  function automatic logic [7:0] rand_separator();
    case ($urandom_range(7))
      0:       return 8'($urandom_range(47, 0));
      1:       return 8'($urandom_range(64, 58));
      2:       return 8'($urandom_range(96, 91));
      3:       return 8'($urandom_range(127, 123));
      default: return 8'($urandom_range(255, 128));
    endcase
  endfunction

  // A well-formed word of len characters with random content. When pick_end
  // is set the ending is picked at random; otherwise it is an end of file
  // when end_by_eof is set and a random separator when not.
  task automatic send_word(input int unsigned len, input bit pick_end, input bit end_by_eof);
    bit eof_end;
    eof_end = pick_end ? ($urandom_range(4) == 0) : end_by_eof;
    drive_item(KIND_DATA, rand_letter());
    for (int unsigned i = 1; i < len; i++) begin
      if ($urandom_range(9) < 7) begin
        drive_item(KIND_DATA, rand_letter());
      end else begin
        drive_item(KIND_DATA, 8'h30 + 8'($urandom_range(9)));
      end
    end
    if (eof_end) begin
      drive_item(KIND_EOF, 8'($urandom_range(255)));
    end else begin
      drive_item(KIND_DATA, rand_separator());
    end
    if (len >= WORD_MAX - 1) begin
      long_words++;
    end
  endtask

  function automatic int unsigned rand_word_len();
    if ($urandom_range(19) == 0) begin
      return $urandom_range(WORD_MAX + 6, WORD_MAX - 4);
    end
    return $urandom_range(9, 1);
  endfunction

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    kind_i      = KIND_DATA;
    data_byte_i = 8'h00;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening. An end of file with no word pending, carrying an
    // extreme byte that must be ignored.
    drive_item(KIND_EOF, 8'hFF);
    // A short word ended by a byte above 127.
    send_text("ab");
    drive_item(KIND_DATA, 8'hFF);
    // A single-character word gives nothing.
    send_text("x");
    drive_item(KIND_DATA, 8'h00);
    // Letters of both cases and both digit borders, emitted by end of file.
    send_text("Zz09");
    drive_item(KIND_EOF, 8'h00);
    // A digit cannot start a word; the byte just below 'A' ends one.
    send_text("5AB@");
    // Single characters and short words ended by a byte above 127 and by class borders.
    send_text("q");
    drive_item(KIND_DATA, 8'h80);
    send_text("Ma[y`k:");
    send_text("Ab{");
    drive_item(KIND_EOF, 8'h5A);

    // Words at and around the buffer size: the longest emitted word ended by
    // a separator, a word truncated on its last buffer slot and then closed
    // by end of file, and an over-long word whose tail is ignored.
    send_word(WORD_MAX - 1, 1'b0, 1'b0);
    send_word(WORD_MAX, 1'b0, 1'b1);
    send_word(WORD_MAX + 3, 1'b0, 1'b0);

    // Random part: mostly well-formed words with random content, the rest
    // raw bytes and stray ends of file that break words at odd places.
    while (bytes_taken < RANDOM_ITEMS) begin
      noise_on = !(bytes_taken >= 140 && bytes_taken < 200);
      if (!holdoff_done && bytes_taken >= 210) begin
        // Keep offering words while the receiver holds off, then let the
        // block drain completely before going on.
        holdoff_go = 1'b1;
        while (!holdoff_done) begin
          send_word(rand_word_len(), 1'b1, 1'b0);
        end
        in_valid_i <= 1'b0;
        wait (chars_pending == 0);
        @(negedge clk_i);
      end else if ($urandom_range(99) < 15) begin
        drive_item($urandom_range(9) == 0 ? KIND_EOF : KIND_DATA, 8'($urandom_range(255)));
      end else begin
        send_word(rand_word_len(), 1'b1, 1'b0);
      end
    end
    noise_on = 1'b1;
    in_valid_i <= 1'b0;

    // Drain, then give the block time to show any stray character.
    wait (chars_pending == 0);
    repeat (2 * WORD_MAX + 10) @(posedge clk_i);

    $display("Run took %0d input transactions (%0d long words) and checked %0d words",
             bytes_taken, long_words, words_checked);
    $display("with %0d characters, under random idling and one long receiver hold-off",
             chars_checked);
    if (mismatches == 0 && chars_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
